/* rtl/ifd_pkg.sv */
package ifd_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int TDATA_W  = 40;
    localparam int FIELDS_W = 2 * BYTE_W + 2 + LEN_W;

    localparam logic [BYTE_W-1:0] FLAG_BYTE  = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FLAG   = 8'h5E;
    localparam logic [BYTE_W-1:0] ESC_ESC    = 8'h5D;
    localparam logic [BYTE_W-1:0] SEQ0_CTRL  = 8'h00;
    localparam logic [BYTE_W-1:0] SEQ1_CTRL  = 8'h80;
    localparam logic [BYTE_W-1:0] RR_NEXT1   = 8'hAB;
    localparam logic [BYTE_W-1:0] RR_NEXT0   = 8'hAA;
    localparam logic [BYTE_W-1:0] REJ_SEQ0   = 8'h54;
    localparam logic [BYTE_W-1:0] REJ_SEQ1   = 8'h55;
    localparam logic [BYTE_W-1:0] SEQ_RESET  = 8'h12;
    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h03;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] reply_control;
        logic              deliver;
        logic              check_good;
        logic [BYTE_W-1:0] payload_byte;
    } result_fields_t;

endpackage

/* rtl/info_frame_deframer.sv */
// Information frame deframer for a byte-stuffed serial link.
// The s_axis channel takes one raw line byte per word in s_axis_tdata. The
// block finds the opening flag, the address (matched against the value last
// written through cfg_we/cfg_data), the control byte with the sequence bit and
// the header check, then removes escape stuffing and holds back the last
// destuffed byte as the check byte.
// The m_axis channel gives zero or one word per input word: a payload byte
// (tuser 0) for each destuffed byte except the last one, and a verdict word
// (tuser 1) at the closing flag with the check result, the delivery decision,
// the reply control byte and the payload length, which saturates at 65535.
// A byte passes an input register and a result register, and the result
// register presents its word on m_axis. One byte is
// accepted every cycle as long as the receiver takes words; the per-byte
// logic between the two registers sets this figure.
// When the receiver stalls, the result register holds its word and the input
// register holds the next byte; s_axis_tready falls only when both are full.
// Reset clears both registers, returns the block to hunting for a flag and
// sets the address register to 0x03.
module info_frame_deframer
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ifd_pkg::BYTE_W-1:0]      cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // rx_byte in bits 7:0.
    input  logic [ifd_pkg::BYTE_W-1:0]      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // payload_byte 7:0, check_good 8, deliver 9, reply_control 17:10,
    // payload_length 33:18, zeros above.
    output logic [ifd_pkg::TDATA_W-1:0]     m_axis_tdata,
    // item_kind in bit 0.
    output logic                            m_axis_tuser
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    logic [ifd_pkg::BYTE_W-1:0]   addr_reg;
    logic                         in_valid_reg;
    logic [ifd_pkg::BYTE_W-1:0]   in_byte_reg;
    phase_t                       phase_reg, phase_next;
    logic                         esc_reg, esc_next;
    logic [ifd_pkg::BYTE_W-1:0]   xor_reg, xor_next;
    logic [ifd_pkg::BYTE_W-1:0]   held_reg, held_next;
    logic                         held_valid_reg, held_valid_next;
    logic [ifd_pkg::LEN_W-1:0]    total_reg, total_next;
    logic [ifd_pkg::BYTE_W-1:0]   seq_reg, seq_next;
    logic                         changed_reg, changed_next;
    logic [ifd_pkg::BYTE_W-1:0]   reply_reg, reply_next;
    logic                         out_valid_reg;
    logic                         out_kind_reg;
    ifd_pkg::result_fields_t      out_fields_reg;

    logic                         advance;
    logic                         work;
    logic                         emit;
    logic                         emit_kind;
    ifd_pkg::result_fields_t      res;
    logic                         take;
    logic [ifd_pkg::BYTE_W-1:0]   take_byte;
    logic                         good;
    logic [ifd_pkg::BYTE_W-1:0]   b;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign work          = in_valid_reg && advance;
    assign b             = in_byte_reg;
    assign good          = (xor_reg == '0);

    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        xor_next        = xor_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        total_next      = total_reg;
        seq_next        = seq_reg;
        changed_next    = changed_reg;
        reply_next      = reply_reg;
        emit            = 1'b0;
        emit_kind       = ifd_pkg::KIND_PAYLOAD;
        res             = '0;
        take            = 1'b0;
        take_byte       = b;
        case (phase_reg)
            PH_FLAG:
            begin
                if (b == addr_reg)
                    phase_next = PH_ADDR;
                else if (b != ifd_pkg::FLAG_BYTE)
                    phase_next = PH_HUNT;
            end
            PH_ADDR:
            begin
                if (b == ifd_pkg::SEQ0_CTRL || b == ifd_pkg::SEQ1_CTRL)
                begin
                    changed_next = (seq_reg != b);
                    seq_next     = b;
                    phase_next   = PH_CTRL;
                end
                else if (b == ifd_pkg::FLAG_BYTE)
                    phase_next = PH_FLAG;
                else
                    phase_next = PH_HUNT;
            end
            PH_CTRL:
            begin
                if (b == (addr_reg ^ seq_reg))
                begin
                    esc_next        = 1'b0;
                    xor_next        = '0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    total_next      = '0;
                    phase_next      = PH_DATA;
                end
                else if (b == ifd_pkg::FLAG_BYTE)
                    phase_next = PH_FLAG;
                else
                    phase_next = PH_HUNT;
            end
            PH_DATA:
            begin
                if (b == ifd_pkg::FLAG_BYTE)
                begin
                    if (good)
                    begin
                        if (seq_reg == ifd_pkg::SEQ0_CTRL)
                            reply_next = ifd_pkg::RR_NEXT1;
                        else if (seq_reg == ifd_pkg::SEQ1_CTRL)
                            reply_next = ifd_pkg::RR_NEXT0;
                    end
                    else
                    begin
                        if (seq_reg == ifd_pkg::SEQ0_CTRL)
                            reply_next = ifd_pkg::REJ_SEQ0;
                        else if (seq_reg == ifd_pkg::SEQ1_CTRL)
                            reply_next = ifd_pkg::REJ_SEQ1;
                    end
                    emit               = 1'b1;
                    emit_kind          = ifd_pkg::KIND_VERDICT;
                    res.check_good     = good;
                    res.deliver        = good && (changed_reg
                                         || reply_reg == ifd_pkg::REJ_SEQ0
                                         || reply_reg == ifd_pkg::REJ_SEQ1);
                    res.reply_control  = reply_next;
                    res.payload_length = total_reg;
                    esc_next        = 1'b0;
                    xor_next        = '0;
                    held_next       = '0;
                    held_valid_next = 1'b0;
                    total_next      = '0;
                    phase_next      = PH_HUNT;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (b == ifd_pkg::ESC_FLAG)
                    begin
                        take      = 1'b1;
                        take_byte = ifd_pkg::FLAG_BYTE;
                    end
                    else if (b == ifd_pkg::ESC_ESC)
                    begin
                        take      = 1'b1;
                        take_byte = ifd_pkg::ESC_BYTE;
                    end
                end
                else if (b == ifd_pkg::ESC_BYTE)
                    esc_next = 1'b1;
                else
                    take = 1'b1;
            end
            default:
            begin
                phase_next = (b == ifd_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
            end
        endcase
        if (take)
        begin
            xor_next        = xor_reg ^ take_byte;
            held_next       = take_byte;
            held_valid_next = 1'b1;
            if (held_valid_reg)
            begin
                emit             = 1'b1;
                res.payload_byte = held_reg;
                if (total_reg != ifd_pkg::LEN_MAX)
                    total_next = total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= ifd_pkg::ADDR_RESET;
            in_valid_reg   <= 1'b0;
            in_byte_reg    <= '0;
            phase_reg      <= PH_HUNT;
            esc_reg        <= 1'b0;
            xor_reg        <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            total_reg      <= '0;
            seq_reg        <= ifd_pkg::SEQ_RESET;
            changed_reg    <= 1'b1;
            reply_reg      <= ifd_pkg::SEQ_RESET;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= ifd_pkg::KIND_PAYLOAD;
            out_fields_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                addr_reg <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_axis_tdata;
            end
            else if (work)
                in_valid_reg <= 1'b0;
            if (work)
            begin
                phase_reg      <= phase_next;
                esc_reg        <= esc_next;
                xor_reg        <= xor_next;
                held_reg       <= held_next;
                held_valid_reg <= held_valid_next;
                total_reg      <= total_next;
                seq_reg        <= seq_next;
                changed_reg    <= changed_next;
                reply_reg      <= reply_next;
            end
            if (advance)
            begin
                out_valid_reg  <= work && emit;
                out_kind_reg   <= emit_kind;
                out_fields_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {{(ifd_pkg::TDATA_W - ifd_pkg::FIELDS_W){1'b0}}, out_fields_reg};

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ifd_pkg::KIND_PAYLOAD)
            |-> (m_axis_tdata[ifd_pkg::TDATA_W-1:ifd_pkg::BYTE_W] == '0))
        else $error("payload word carries verdict fields");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ifd_pkg::KIND_VERDICT)
            |-> (m_axis_tdata[ifd_pkg::BYTE_W-1:0] == '0))
        else $error("verdict word carries a payload byte");

    a_deliver_good: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_fields_reg.deliver) |-> out_fields_reg.check_good)
        else $error("delivery without a good check");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (work && phase_reg == PH_DATA && in_byte_reg == ifd_pkg::FLAG_BYTE)
            |=> (phase_reg == PH_HUNT && !held_valid_reg && total_reg == '0
                 && out_valid_reg))
        else $error("closing flag did not end the frame");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

endmodule

/* tb/deframer_checker.sv */
`timescale 1ns / 1ps

module deframer_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ifd_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [ifd_pkg::BYTE_W-1:0]  s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [ifd_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic                        m_axis_tuser,
    output int                          mismatches,
    output int                          backlog
);

    typedef enum logic [2:0] {PH_HUNT, PH_FLAG, PH_ADDR, PH_CTRL, PH_DATA} rx_phase_t;

    typedef logic [ifd_pkg::TDATA_W-1:0] wide_t;

    typedef struct packed {
        logic                    kind;
        ifd_pkg::result_fields_t f;
    } out_word_t;

    rx_phase_t                  phase;
    logic                       esc_pending;
    logic [ifd_pkg::BYTE_W-1:0] frame_xor;
    logic [ifd_pkg::BYTE_W-1:0] held_byte;
    logic                       held_valid;
    logic [ifd_pkg::LEN_W-1:0]  payload_count;
    logic [ifd_pkg::BYTE_W-1:0] seq_ctrl;
    logic                       seq_new;
    logic [ifd_pkg::BYTE_W-1:0] reply_ctrl;
    logic [ifd_pkg::BYTE_W-1:0] station_addr;
    out_word_t                  expected_words[$];

    initial
    begin
        mismatches = 0;
        backlog    = 0;
    end

    task automatic report_mismatch(input string what, input wide_t got, input wide_t want);
        $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_frame();
        esc_pending   = 1'b0;
        frame_xor     = '0;
        held_byte     = '0;
        held_valid    = 1'b0;
        payload_count = '0;
    endtask

    // The newest destuffed byte is held back, since it may be the check byte.
    task automatic absorb_byte(input logic [ifd_pkg::BYTE_W-1:0] b);
        out_word_t w;
        frame_xor = frame_xor ^ b;
        if (held_valid)
        begin
            w                = '0;
            w.kind           = ifd_pkg::KIND_PAYLOAD;
            w.f.payload_byte = held_byte;
            expected_words.push_back(w);
            if (payload_count != ifd_pkg::LEN_MAX)
                payload_count++;
        end
        held_byte  = b;
        held_valid = 1'b1;
    endtask

    task automatic advance_deframer(input logic [ifd_pkg::BYTE_W-1:0] b);
        out_word_t w;
        logic      good;
        case (phase)
            PH_FLAG:
            begin
                if (b == station_addr)
                    phase = PH_ADDR;
                else if (b != ifd_pkg::FLAG_BYTE)
                    phase = PH_HUNT;
            end
            PH_ADDR:
            begin
                if (b == ifd_pkg::SEQ0_CTRL || b == ifd_pkg::SEQ1_CTRL)
                begin
                    seq_new  = (seq_ctrl != b);
                    seq_ctrl = b;
                    phase    = PH_CTRL;
                end
                else if (b == ifd_pkg::FLAG_BYTE)
                    phase = PH_FLAG;
                else
                    phase = PH_HUNT;
            end
            PH_CTRL:
            begin
                if (b == (station_addr ^ seq_ctrl))
                begin
                    clear_frame();
                    phase = PH_DATA;
                end
                else if (b == ifd_pkg::FLAG_BYTE)
                    phase = PH_FLAG;
                else
                    phase = PH_HUNT;
            end
            PH_DATA:
            begin
                if (b == ifd_pkg::FLAG_BYTE)
                begin
                    good              = (frame_xor == '0);
                    w                 = '0;
                    w.kind            = ifd_pkg::KIND_VERDICT;
                    w.f.check_good    = good;
                    w.f.deliver       = good && (seq_new
                                                 || reply_ctrl == ifd_pkg::REJ_SEQ0
                                                 || reply_ctrl == ifd_pkg::REJ_SEQ1);
                    if (seq_ctrl == ifd_pkg::SEQ0_CTRL)
                        reply_ctrl = good ? ifd_pkg::RR_NEXT1 : ifd_pkg::REJ_SEQ0;
                    else if (seq_ctrl == ifd_pkg::SEQ1_CTRL)
                        reply_ctrl = good ? ifd_pkg::RR_NEXT0 : ifd_pkg::REJ_SEQ1;
                    w.f.reply_control  = reply_ctrl;
                    w.f.payload_length = payload_count;
                    expected_words.push_back(w);
                    clear_frame();
                    phase = PH_HUNT;
                end
                else if (esc_pending)
                begin
                    esc_pending = 1'b0;
                    if (b == ifd_pkg::ESC_FLAG)
                        absorb_byte(ifd_pkg::FLAG_BYTE);
                    else if (b == ifd_pkg::ESC_ESC)
                        absorb_byte(ifd_pkg::ESC_BYTE);
                end
                else if (b == ifd_pkg::ESC_BYTE)
                    esc_pending = 1'b1;
                else
                    absorb_byte(b);
            end
            default:
                phase = (b == ifd_pkg::FLAG_BYTE) ? PH_FLAG : PH_HUNT;
        endcase
    endtask

    task automatic check_word();
        out_word_t               want;
        ifd_pkg::result_fields_t got;
        got = m_axis_tdata[ifd_pkg::FIELDS_W-1:0];
        if (expected_words.size() == 0)
            report_mismatch("unexpected word", m_axis_tdata, '0);
        else
        begin
            want = expected_words.pop_front();
            if (m_axis_tuser !== want.kind)
                report_mismatch("item_kind", wide_t'(m_axis_tuser), wide_t'(want.kind));
            if (got.payload_byte !== want.f.payload_byte)
                report_mismatch("payload_byte", wide_t'(got.payload_byte),
                                wide_t'(want.f.payload_byte));
            if (got.check_good !== want.f.check_good)
                report_mismatch("check_good", wide_t'(got.check_good),
                                wide_t'(want.f.check_good));
            if (got.deliver !== want.f.deliver)
                report_mismatch("deliver", wide_t'(got.deliver), wide_t'(want.f.deliver));
            if (got.reply_control !== want.f.reply_control)
                report_mismatch("reply_control", wide_t'(got.reply_control),
                                wide_t'(want.f.reply_control));
            if (got.payload_length !== want.f.payload_length)
                report_mismatch("payload_length", wide_t'(got.payload_length),
                                wide_t'(want.f.payload_length));
            if (m_axis_tdata[ifd_pkg::TDATA_W-1:ifd_pkg::FIELDS_W] !== '0)
                report_mismatch("tdata padding",
                                wide_t'(m_axis_tdata[ifd_pkg::TDATA_W-1:ifd_pkg::FIELDS_W]),
                                '0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_addr = ifd_pkg::ADDR_RESET;
            phase        = PH_HUNT;
            clear_frame();
            seq_ctrl     = ifd_pkg::SEQ_RESET;
            seq_new      = 1'b1;
            reply_ctrl   = ifd_pkg::SEQ_RESET;
            expected_words.delete();
            backlog      = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_word();
            if (cfg_we)
                station_addr = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                advance_deframer(s_axis_tdata);
            backlog = expected_words.size();
        end
    end

endmodule

/* tb/info_frame_deframer_tb.sv */
`timescale 1ns / 1ps

module info_frame_deframer_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_BYTES = 850;
    localparam int ADDR_PHASES  = 5;

    typedef enum int {
        HDR_CLEAN,
        HDR_DOUBLE_FLAG,
        HDR_FLAG_FOR_CTRL,
        HDR_FLAG_FOR_CHECK,
        HDR_BAD_CHECK,
        HDR_BAD_ADDR,
        HDR_BAD_CTRL
    } header_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [ifd_pkg::BYTE_W-1:0]  cfg_data;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [ifd_pkg::BYTE_W-1:0]  s_axis_tdata;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [ifd_pkg::TDATA_W-1:0] m_axis_tdata;
    logic                        m_axis_tuser;

    int                          mismatches;
    int                          backlog;

    // When set, neither side inserts idle cycles.
    logic                        steady;
    logic [ifd_pkg::BYTE_W-1:0]  station_addr;
    logic [ifd_pkg::BYTE_W-1:0]  line_bytes[$];
    int                          sent_bytes;

    info_frame_deframer u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    deframer_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .mismatches    (mismatches),
        .backlog       (backlog)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("** info_frame_deframer: FAILED **");
        $finish;
    end

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    task automatic send_byte(input logic [ifd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        sent_bytes++;
    endtask

    task automatic send_line();
        while (line_bytes.size() > 0)
            send_byte(line_bytes.pop_front());
    endtask

    // Lets every expected word arrive and any byte still inside the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (backlog != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_address(input logic [ifd_pkg::BYTE_W-1:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        station_addr = value;
    endtask

    function automatic void push_stuffed(input logic [ifd_pkg::BYTE_W-1:0] b);
        if (b == ifd_pkg::FLAG_BYTE)
        begin
            line_bytes.push_back(ifd_pkg::ESC_BYTE);
            line_bytes.push_back(ifd_pkg::ESC_FLAG);
        end
        else if (b == ifd_pkg::ESC_BYTE)
        begin
            line_bytes.push_back(ifd_pkg::ESC_BYTE);
            line_bytes.push_back(ifd_pkg::ESC_ESC);
        end
        else
            line_bytes.push_back(b);
    endfunction

    function automatic void push_frame(input logic [ifd_pkg::BYTE_W-1:0] addr,
                                       input logic [ifd_pkg::BYTE_W-1:0] ctrl, input int len,
                                       input header_mode_t mode, input bit corrupt,
                                       input bit quirks);
        logic [ifd_pkg::BYTE_W-1:0] hdr_addr;
        logic [ifd_pkg::BYTE_W-1:0] hdr_ctrl;
        logic [ifd_pkg::BYTE_W-1:0] hdr_check;
        logic [ifd_pkg::BYTE_W-1:0] sum;
        logic [ifd_pkg::BYTE_W-1:0] b;
        hdr_addr  = addr;
        hdr_ctrl  = ctrl;
        hdr_check = addr ^ ctrl;
        sum       = '0;
        line_bytes.push_back(ifd_pkg::FLAG_BYTE);
        case (mode)
            HDR_DOUBLE_FLAG:
                line_bytes.push_back(ifd_pkg::FLAG_BYTE);
            HDR_FLAG_FOR_CTRL:
            begin
                line_bytes.push_back(addr);
                line_bytes.push_back(ifd_pkg::FLAG_BYTE);
            end
            HDR_FLAG_FOR_CHECK:
            begin
                line_bytes.push_back(addr);
                line_bytes.push_back(ctrl);
                line_bytes.push_back(ifd_pkg::FLAG_BYTE);
            end
            HDR_BAD_CHECK:
                hdr_check = hdr_check ^ 8'($urandom_range(1, 255));
            HDR_BAD_ADDR:
                hdr_addr = hdr_addr ^ 8'($urandom_range(1, 255));
            HDR_BAD_CTRL:
            begin
                hdr_ctrl = 8'($urandom_range(0, 255));
                if (hdr_ctrl == ifd_pkg::SEQ0_CTRL || hdr_ctrl == ifd_pkg::SEQ1_CTRL)
                    hdr_ctrl = hdr_ctrl ^ 8'h01;
            end
            default: ;
        endcase
        line_bytes.push_back(hdr_addr);
        line_bytes.push_back(hdr_ctrl);
        line_bytes.push_back(hdr_check);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                b = $urandom_range(0, 1) ? ifd_pkg::FLAG_BYTE : ifd_pkg::ESC_BYTE;
            else
                b = 8'($urandom_range(0, 255));
            sum = sum ^ b;
            push_stuffed(b);
            if (quirks && $urandom_range(0, 4) == 0)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == ifd_pkg::ESC_FLAG || b == ifd_pkg::ESC_ESC
                    || b == ifd_pkg::FLAG_BYTE)
                    b = 8'h33;
                line_bytes.push_back(ifd_pkg::ESC_BYTE);
                line_bytes.push_back(b);
            end
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        if (len > 0 || corrupt || $urandom_range(0, 1) == 1)
            push_stuffed(sum);
        if (quirks && $urandom_range(0, 2) == 0)
            line_bytes.push_back(ifd_pkg::ESC_BYTE);
        line_bytes.push_back(ifd_pkg::FLAG_BYTE);
    endfunction

    task automatic send_random_frames(input int count);
        int                         stop_at;
        int                         pick;
        int                         len;
        logic [ifd_pkg::BYTE_W-1:0] ctrl;
        stop_at = sent_bytes + count;
        while (sent_bytes < stop_at)
        begin
            pick = $urandom_range(0, 19);
            ctrl = $urandom_range(0, 1) ? ifd_pkg::SEQ1_CTRL : ifd_pkg::SEQ0_CTRL;
            len  = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (pick < 12)
                push_frame(station_addr, ctrl, len, HDR_CLEAN, $urandom_range(0, 4) == 0,
                           $urandom_range(0, 3) == 0);
            else if (pick < 17)
                push_frame(station_addr, ctrl, len, header_mode_t'($urandom_range(1, 6)),
                           $urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0);
            else
                repeat ($urandom_range(1, 6))
                    line_bytes.push_back(8'($urandom_range(0, 255)));
            send_line();
        end
    endtask

    initial
    begin
        logic [ifd_pkg::BYTE_W-1:0] addr_plan[ADDR_PHASES];
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady        = 1'b0;
        station_addr  = ifd_pkg::ADDR_RESET;
        sent_bytes    = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A good frame with both stuffed codes, an empty frame, a bad frame with an
        // unknown escape and an escape left open at the closing flag, then a
        // retransmission after the reject behind a repeated flag and flags in
        // place of the control and the header check.
        line_bytes = '{ifd_pkg::FLAG_BYTE, ifd_pkg::ADDR_RESET, ifd_pkg::SEQ0_CTRL,
                       ifd_pkg::ADDR_RESET ^ ifd_pkg::SEQ0_CTRL,
                       ifd_pkg::ESC_BYTE, ifd_pkg::ESC_FLAG, ifd_pkg::ESC_BYTE,
                       ifd_pkg::ESC_ESC, 8'h00, 8'hFF, 8'hFC, ifd_pkg::FLAG_BYTE,
                       ifd_pkg::FLAG_BYTE, ifd_pkg::ADDR_RESET, ifd_pkg::SEQ1_CTRL,
                       ifd_pkg::ADDR_RESET ^ ifd_pkg::SEQ1_CTRL, ifd_pkg::FLAG_BYTE,
                       ifd_pkg::FLAG_BYTE, ifd_pkg::ADDR_RESET, ifd_pkg::SEQ1_CTRL,
                       ifd_pkg::ADDR_RESET ^ ifd_pkg::SEQ1_CTRL,
                       8'h12, ifd_pkg::ESC_BYTE, 8'h33, ifd_pkg::ESC_BYTE,
                       ifd_pkg::FLAG_BYTE,
                       ifd_pkg::FLAG_BYTE, ifd_pkg::FLAG_BYTE, ifd_pkg::ADDR_RESET,
                       ifd_pkg::FLAG_BYTE, ifd_pkg::ADDR_RESET, ifd_pkg::SEQ1_CTRL,
                       ifd_pkg::FLAG_BYTE, ifd_pkg::ADDR_RESET, ifd_pkg::SEQ1_CTRL,
                       ifd_pkg::ADDR_RESET ^ ifd_pkg::SEQ1_CTRL, 8'h00,
                       ifd_pkg::FLAG_BYTE};
        send_line();

        addr_plan = '{8'h00, 8'hFF, ifd_pkg::FLAG_BYTE, 8'($urandom_range(0, 255)),
                      ifd_pkg::ADDR_RESET};
        for (int p = 0; p < ADDR_PHASES; p++)
        begin
            write_address(addr_plan[p]);
            steady = (p == 2);
            send_random_frames(RANDOM_BYTES / ADDR_PHASES);
        end
        steady = 1'b0;

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("** info_frame_deframer: PASSED **");
        else
            $display("** info_frame_deframer: FAILED **");
        $finish;
    end

endmodule
